// ===== rtl/cfp_pkg.sv =====
// Shared types and constants for the command frame parser.
package cfp_pkg;

    localparam int unsigned POS_W     = 17;

    localparam logic [POS_W-1:0] POS_MAX    = {POS_W{1'b1}};
    localparam logic [POS_W-1:0] MIN_FRAME  = POS_W'(7);
    localparam logic [POS_W-1:0] HDR_END    = POS_W'(7);
    localparam logic [15:0]      LEN_OVHD   = 16'd5;
    localparam logic [15:0]      EVT_SIZE   = 16'd2;

    typedef logic [2:0] status_t;

    localparam status_t ST_OK       = 3'd0;
    localparam status_t ST_SHORT    = 3'd1;
    localparam status_t ST_BAD_SYNC = 3'd2;
    localparam status_t ST_LEN_ERR  = 3'd3;
    localparam status_t ST_CSUM_ERR = 3'd4;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [7:0]  payload;
        status_t     status;
        logic [7:0]  seq;
        logic [15:0] event_code;
        logic [15:0] length;
        logic        frame_end;
    } result_t;

    typedef struct packed {
        logic    pay_valid;
        result_t pay;
        logic    stat_valid;
        result_t stat;
    } push_t;

endpackage

// ===== rtl/cfp_core.sv =====
// Frame parsing state: position, checksum, header fields and result generation.
module cfp_core
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           accept,
    input  logic [7:0]     rx_byte,
    input  logic           end_of_frame,
    input  logic [7:0]     sync_value,
    output cfp_pkg::push_t push
);
    import cfp_pkg::*;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       sum_reg, sum_next;
    logic [15:0]      len_reg, len_next;
    logic [7:0]       seq_reg, seq_next;
    logic [15:0]      evt_reg, evt_next;
    logic [7:0]       held_reg, held_next;
    logic             sync_good_reg, sync_good_next;

    logic [POS_W:0]   count;
    logic [POS_W:0]   len_plus;
    logic [7:0]       csum;
    status_t          status;

    assign count    = {1'b0, pos_reg} + (POS_W+1)'(1);
    assign len_plus = (POS_W+1)'({1'b0, len_reg} + {1'b0, LEN_OVHD});
    assign csum     = 8'd0 - sum_reg;

    always_comb
    begin
        priority if (pos_reg < (MIN_FRAME - POS_W'(1)))
            status = ST_SHORT;
        else if (!sync_good_reg)
            status = ST_BAD_SYNC;
        else if (len_plus != count)
            status = ST_LEN_ERR;
        else if (csum != rx_byte)
            status = ST_CSUM_ERR;
        else
            status = ST_OK;
    end

    always_comb
    begin
        push = '0;
        push.pay_valid       = accept && (pos_reg >= HDR_END);
        push.pay.kind        = KIND_PAYLOAD;
        push.pay.payload     = held_reg;
        push.stat_valid      = accept && end_of_frame;
        push.stat.kind       = KIND_STATUS;
        push.stat.status     = status;
        push.stat.seq        = seq_reg;
        push.stat.event_code = evt_reg;
        push.stat.length     = (status == ST_OK) ? (len_reg - EVT_SIZE) : 16'd0;
        push.stat.frame_end  = 1'b1;
    end

    always_comb
    begin
        pos_next       = pos_reg;
        sum_next       = sum_reg;
        len_next       = len_reg;
        seq_next       = seq_reg;
        evt_next       = evt_reg;
        held_next      = held_reg;
        sync_good_next = sync_good_reg;
        if (accept)
        begin
            if (end_of_frame)
            begin
                pos_next       = '0;
                sum_next       = '0;
                len_next       = '0;
                seq_next       = '0;
                evt_next       = '0;
                held_next      = '0;
                sync_good_next = 1'b0;
            end
            else
            begin
                if (pos_reg == '0)
                begin
                    sum_next       = '0;
                    len_next       = '0;
                    seq_next       = '0;
                    evt_next       = '0;
                    held_next      = '0;
                    sync_good_next = (rx_byte == sync_value);
                end
                else
                begin
                    sum_next = sum_reg + rx_byte;
                    unique case (pos_reg)
                        POS_W'(1): seq_next         = rx_byte;
                        POS_W'(2): len_next[7:0]    = rx_byte;
                        POS_W'(3): len_next[15:8]   = rx_byte;
                        POS_W'(4): evt_next[7:0]    = rx_byte;
                        POS_W'(5): evt_next[15:8]   = rx_byte;
                        default:   held_next        = rx_byte;
                    endcase
                end
                if (pos_reg != POS_MAX)
                    pos_next = pos_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            sum_reg       <= '0;
            len_reg       <= '0;
            seq_reg       <= '0;
            evt_reg       <= '0;
            held_reg      <= '0;
            sync_good_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            sum_reg       <= sum_next;
            len_reg       <= len_next;
            seq_reg       <= seq_next;
            evt_reg       <= evt_next;
            held_reg      <= held_next;
            sync_good_reg <= sync_good_next;
        end
    end

endmodule

// ===== rtl/cfp_out_queue.sv =====
// Three-entry result queue taking up to two results per cycle.
module cfp_out_queue
(
    input  logic             clk,
    input  logic             rst_n,
    input  cfp_pkg::push_t   push,
    input  logic             pop,
    output logic             room,
    output logic             head_valid,
    output cfp_pkg::result_t head
);
    import cfp_pkg::*;

    localparam int unsigned DEPTH = 3;

    result_t    q_reg  [DEPTH];
    result_t    q_next [DEPTH];
    logic [1:0] cnt_reg, cnt_next;

    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
            q_next[i] = q_reg[i];
        cnt_next = cnt_reg;
        if (pop)
        begin
            q_next[0] = q_reg[1];
            q_next[1] = q_reg[2];
            cnt_next  = cnt_next - 2'd1;
        end
        if (push.pay_valid && cnt_next < 2'(DEPTH))
        begin
            q_next[cnt_next] = push.pay;
            cnt_next         = cnt_next + 2'd1;
        end
        if (push.stat_valid && cnt_next < 2'(DEPTH))
        begin
            q_next[cnt_next] = push.stat;
            cnt_next         = cnt_next + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DEPTH; i++)
            q_reg[i] <= q_next[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    assign room       = (cnt_reg <= 2'd1);
    assign head_valid = (cnt_reg != 2'd0);
    assign head       = q_reg[0];

endmodule

// ===== rtl/command_frame_parser.sv =====
// Command frame parser top level: byte stream in, payload and status results out.
// Each result is registered in the output queue before it reaches the master side.
// Throughput: one byte per cycle while s_tready is high; an end-of-frame byte after the
// header gives two results to a three-entry output queue (s_tready low at 2 or more held).
// Reset (rst_n low, asynchronous) clears frame state, the queue and sync_value to zero.
module command_frame_parser
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [7:0] payload_byte, [10:8] frame_status,
                                   // [18:11] seq_number, [34:19] event_code,
                                   // [50:35] payload_length, [55:51] zero
    output logic        m_tuser,   // result_kind
    output logic        m_tlast    // frame_end
);
    import cfp_pkg::*;

    logic [7:0] sync_reg;
    logic       accept;
    logic       room;
    logic       head_valid;
    push_t      push;
    result_t    head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sync_reg <= '0;
        else if (cfg_we)
            sync_reg <= cfg_wdata;
    end

    assign s_tready = room;
    assign accept   = s_tvalid && s_tready;

    cfp_core u_core
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .rx_byte      (s_tdata),
        .end_of_frame (s_tlast),
        .sync_value   (sync_reg),
        .push         (push)
    );

    cfp_out_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .pop        (m_tvalid && m_tready),
        .room       (room),
        .head_valid (head_valid),
        .head       (head)
    );

    assign m_tvalid = head_valid;
    assign m_tuser  = head.kind;
    assign m_tlast  = head.frame_end;
    assign m_tdata  = {5'd0, head.length, head.event_code, head.seq,
                       head.status, head.payload};

endmodule

// ===== tb/command_frame_parser_test.sv =====
// Self-checking testbench for command_frame_parser: directed and random frames.
`timescale 1ns / 1ps

module command_frame_parser_test;
    import cfp_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 120;
    localparam int DRAIN_CYCLES = 3;
    localparam int RANDOM_ITEMS = 620;
    localparam int DIR_ROWS     = 30;

    typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_CYCLIC} rx_mode_t;
    typedef enum {FR_GOOD, FR_BAD_CSUM, FR_BAD_LEN, FR_BAD_SYNC, FR_SHORT, FR_NOISE} frame_kind_t;

    typedef struct packed {
        logic [7:0] rx;
        logic       eof;
        logic       fixed_en;
        result_t    fixed;
    } dir_row_t;

    localparam result_t NONE = '0;

    localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
        '{8'h00, 1'b1, 1'b1,
          '{KIND_STATUS, 8'h00, ST_SHORT, 8'h00, 16'h0000, 16'h0000, 1'b1}},
        '{8'h00, 1'b0, 1'b0, NONE},
        '{8'hFF, 1'b0, 1'b0, NONE},
        '{8'h02, 1'b0, 1'b0, NONE},
        '{8'h00, 1'b0, 1'b0, NONE},
        '{8'hFF, 1'b0, 1'b0, NONE},
        '{8'hFF, 1'b0, 1'b0, NONE},
        '{8'h01, 1'b1, 1'b1,
          '{KIND_STATUS, 8'h00, ST_OK, 8'hFF, 16'hFFFF, 16'h0000, 1'b1}},
        '{8'h80, 1'b0, 1'b0, NONE},
        '{8'h12, 1'b0, 1'b0, NONE},
        '{8'h02, 1'b0, 1'b0, NONE},
        '{8'h00, 1'b0, 1'b0, NONE},
        '{8'h56, 1'b0, 1'b0, NONE},
        '{8'h34, 1'b0, 1'b0, NONE},
        '{8'hAA, 1'b1, 1'b1,
          '{KIND_STATUS, 8'h00, ST_BAD_SYNC, 8'h12, 16'h3456, 16'h0000, 1'b1}},
        '{8'h00, 1'b0, 1'b0, NONE},
        '{8'h00, 1'b0, 1'b0, NONE},
        '{8'hFF, 1'b0, 1'b0, NONE},
        '{8'hFF, 1'b0, 1'b0, NONE},
        '{8'h00, 1'b0, 1'b0, NONE},
        '{8'h00, 1'b0, 1'b0, NONE},
        '{8'h02, 1'b1, 1'b1,
          '{KIND_STATUS, 8'h00, ST_LEN_ERR, 8'h00, 16'h0000, 16'h0000, 1'b1}},
        '{8'h00, 1'b0, 1'b0, NONE},
        '{8'h7F, 1'b0, 1'b0, NONE},
        '{8'h03, 1'b0, 1'b0, NONE},
        '{8'h00, 1'b0, 1'b0, NONE},
        '{8'h01, 1'b0, 1'b0, NONE},
        '{8'h80, 1'b0, 1'b0, NONE},
        '{8'h55, 1'b0, 1'b0, NONE},
        '{8'h57, 1'b1, 1'b1,
          '{KIND_STATUS, 8'h00, ST_CSUM_ERR, 8'h7F, 16'h8001, 16'h0000, 1'b1}}
    };

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we = 1'b0;
    logic [7:0]  cfg_wdata = 8'h00;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;   // [7:0] rx_byte
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;           // [7:0] payload_byte, [10:8] frame_status,
                                    // [18:11] seq_number, [34:19] event_code,
                                    // [50:35] payload_length, [55:51] zero
    logic        m_tuser;           // result_kind
    logic        m_tlast;           // frame_end

    logic        row_fixed_en = 1'b0;
    result_t     row_fixed = '0;
    bit          hold_req = 1'b0;
    bit          hold_taken = 1'b0;
    int          hold_left = 0;
    int          burst_left = 0;
    int          rx_phase = 0;
    rx_mode_t    rx_mode = RX_OPEN;
    int          stall_cycles = 0;
    int          mismatches = 0;

    logic [16:0] frame_pos;
    logic [7:0]  frame_sum;
    logic [15:0] frame_len;
    logic [7:0]  frame_seq;
    logic [15:0] frame_event;
    logic [7:0]  frame_held;
    logic        frame_sync_ok;
    logic [7:0]  sync_reg;

    result_t     expected_results[$];
    logic [7:0]  frame_bytes[$];

    command_frame_parser uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    task automatic clear_frame_state();
        frame_pos     = '0;
        frame_sum     = '0;
        frame_len     = '0;
        frame_seq     = '0;
        frame_event   = '0;
        frame_held    = '0;
        frame_sync_ok = 1'b0;
    endtask

    task automatic parse_byte(input logic [7:0] b, input logic last,
                              input logic fixed_en, input result_t fixed);
        logic [16:0] pos;
        int unsigned count;
        status_t     st;
        result_t     r;
        logic [7:0]  chk;
        pos = frame_pos;
        if (pos >= HDR_END)
        begin
            r = '0;
            r.kind = KIND_PAYLOAD;
            r.payload = frame_held;
            expected_results.push_back(r);
        end
        if (last)
        begin
            count = int'(pos) + 1;
            chk = 8'h00 - frame_sum;
            if (count < int'(MIN_FRAME))
                st = ST_SHORT;
            else if (!frame_sync_ok)
                st = ST_BAD_SYNC;
            else if (int'(frame_len) + int'(LEN_OVHD) != count)
                st = ST_LEN_ERR;
            else if (chk != b)
                st = ST_CSUM_ERR;
            else
                st = ST_OK;
            r = '0;
            r.kind = KIND_STATUS;
            r.status = st;
            r.seq = frame_seq;
            r.event_code = frame_event;
            r.length = (st == ST_OK) ? frame_len - EVT_SIZE : 16'h0000;
            r.frame_end = 1'b1;
            expected_results.push_back(fixed_en ? fixed : r);
            clear_frame_state();
        end
        else
        begin
            if (pos == '0)
            begin
                clear_frame_state();
                frame_sync_ok = (b == sync_reg);
            end
            else
            begin
                frame_sum = frame_sum + b;
                case (pos)
                    17'd1: frame_seq = b;
                    17'd2: frame_len[7:0] = b;
                    17'd3: frame_len[15:8] = b;
                    17'd4: frame_event[7:0] = b;
                    17'd5: frame_event[15:8] = b;
                    default: frame_held = b;
                endcase
            end
            if (pos != POS_MAX)
                frame_pos = pos + 17'd1;
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (!rst_n)
        begin
            sync_reg = '0;
            clear_frame_state();
        end
        else
        begin
            if (cfg_we)
                sync_reg = cfg_wdata;
            if (s_tvalid && s_tready)
                parse_byte(s_tdata, s_tlast, row_fixed_en, row_fixed);
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result with nothing expected: tdata %h tuser %b", m_tdata, m_tuser);
                    mismatches++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("result_kind", 16'(want.kind), 16'(m_tuser));
                    check_field("payload_byte", 16'(want.payload), 16'(m_tdata[7:0]));
                    check_field("frame_status", 16'(want.status), 16'(m_tdata[10:8]));
                    check_field("seq_number", 16'(want.seq), 16'(m_tdata[18:11]));
                    check_field("event_code", want.event_code, m_tdata[34:19]);
                    check_field("payload_length", want.length, m_tdata[50:35]);
                    check_field("frame_end", 16'(want.frame_end), 16'(m_tlast));
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            m_tready = 1'b0;
            hold_left--;
        end
        else if (hold_req && !hold_taken)
        begin
            hold_taken = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            m_tready = 1'b0;
        end
        else
        begin
            if (rx_phase == 0)
            begin
                rx_mode = rx_mode_t'($urandom_range(0, 3));
                rx_phase = $urandom_range(8, 40);
            end
            rx_phase--;
            case (rx_mode)
                RX_OPEN:   m_tready = 1'b1;
                RX_COIN:   m_tready = 1'($urandom_range(0, 1));
                RX_SPARSE: m_tready = ($urandom_range(0, 3) == 0);
                default:   m_tready = (rx_phase % 3 != 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last,
                             input logic fixed_en, input result_t fixed);
        int gap;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
        burst_left--;
        if (gap > 0)
        begin
            @(negedge clk);
            s_tvalid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid = 1'b1;
        s_tdata = b;
        s_tlast = last;
        row_fixed_en = fixed_en;
        row_fixed = fixed;
        do @(posedge clk); while (!s_tready);
    endtask

    // hold input idle until every expected transaction has drained
    task automatic settle();
        @(negedge clk);
        s_tvalid = 1'b0;
        s_tlast = 1'b0;
        while (expected_results.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_sync(input logic [7:0] value);
        settle();
        cfg_we = 1'b1;
        cfg_wdata = value;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    initial
    begin
        int          rnd_items;
        int          frame_count;
        int          plen;
        int          pick;
        frame_kind_t kind;
        logic [7:0]  sync_now;
        logic [7:0]  sum;
        logic [15:0] length_word;

        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < DIR_ROWS; i++)
            send_byte(DIR_TAB[i].rx, DIR_TAB[i].eof, DIR_TAB[i].fixed_en, DIR_TAB[i].fixed);

        sync_now = 8'hFF;
        write_sync(sync_now);

        rnd_items = 0;
        frame_count = 0;
        while (rnd_items < RANDOM_ITEMS)
        begin
            if (frame_count > 0 && frame_count % 12 == 0)
            begin
                case ((frame_count / 12) % 4)
                    0: sync_now = 8'h00;
                    2: sync_now = 8'hFF;
                    default: sync_now = 8'($urandom);
                endcase
                write_sync(sync_now);
            end
            if (frame_count == 25)
                hold_req = 1'b1;

            pick = $urandom_range(0, 99);
            if (pick < 65)
                kind = FR_GOOD;
            else if (pick < 75)
                kind = FR_BAD_CSUM;
            else if (pick < 83)
                kind = FR_BAD_LEN;
            else if (pick < 90)
                kind = FR_BAD_SYNC;
            else if (pick < 97)
                kind = FR_SHORT;
            else
                kind = FR_NOISE;

            frame_bytes.delete();
            if (kind == FR_SHORT || kind == FR_NOISE)
            begin
                plen = (kind == FR_SHORT) ? $urandom_range(1, 6) : $urandom_range(1, 20);
                for (int i = 0; i < plen; i++)
                    frame_bytes.push_back(8'($urandom));
                if (kind == FR_SHORT && $urandom_range(0, 1))
                    frame_bytes[0] = sync_now;
            end
            else
            begin
                plen = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                   : $urandom_range(0, 12);
                length_word = 16'(plen + 2);
                if (kind == FR_BAD_LEN)
                    length_word = length_word ^ 16'($urandom_range(1, 65535));
                frame_bytes.push_back(kind == FR_BAD_SYNC ?
                                      sync_now ^ 8'($urandom_range(1, 255)) : sync_now);
                frame_bytes.push_back(8'($urandom));
                frame_bytes.push_back(length_word[7:0]);
                frame_bytes.push_back(length_word[15:8]);
                frame_bytes.push_back(8'($urandom));
                frame_bytes.push_back(8'($urandom));
                for (int i = 0; i < plen; i++)
                    frame_bytes.push_back(8'($urandom));
                sum = '0;
                for (int i = 1; i < frame_bytes.size(); i++)
                    sum = sum + frame_bytes[i];
                sum = 8'h00 - sum;
                if (kind == FR_BAD_CSUM)
                    sum = sum ^ 8'($urandom_range(1, 255));
                frame_bytes.push_back(sum);
            end

            for (int i = 0; i < frame_bytes.size(); i++)
                send_byte(frame_bytes[i], i == frame_bytes.size() - 1, 1'b0, NONE);
            rnd_items += frame_bytes.size();
            frame_count++;
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
